### rtl/dbl_pkg.sv
// dbl_pkg: shared widths, constants, angle table and sideband types for the
// dual-beam link power pipeline. No dependencies.
package dbl_pkg;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int ANG_W   = 16;
    localparam int PWR_W   = 16;
    localparam int OUT_W   = 18;
    localparam int SUM_W   = 19;
    localparam int HBW_W   = 15;
    localparam int MG_W    = 15;
    localparam int SG_W    = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int TAB_LEN = 24;
    localparam int TAB_W   = 23;
    localparam int VX_W    = 36;
    localparam int Z_W     = 25;
    localparam int Q_W     = 14;
    localparam int RX_W    = 33;
    localparam int DV_W    = 15;
    localparam int NUM_W   = 37;
    localparam int QUO_W   = 23;
    localparam int REM_W   = 15;
    localparam int COS_W   = 31;
    localparam int GAIN_W  = 17;
    localparam int PROD_W  = MG_W + COS_W;

    localparam logic signed [Z_W-1:0]   DEG90    = 25'sd5898240;
    localparam logic [NUM_W-1:0]        DEG90_U  = 37'd5898240;
    localparam logic signed [ANG_W+1:0] ANG180   = 18'sd23040;
    localparam logic signed [ANG_W+1:0] ANG360   = 18'sd46080;
    localparam logic signed [RX_W-1:0]  INV_K    = 33'sd652032874;
    localparam logic signed [RX_W-1:0]  ONE30    = 33'sd1073741824;
    localparam logic [PROD_W-1:0]       HALF30   = 46'd536870912;
    localparam logic signed [SUM_W-1:0] OUT_MAX  = 19'sd131071;
    localparam logic signed [SUM_W-1:0] OUT_MIN  = -19'sd131072;

    localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
        23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
    };

    typedef enum logic [IDX_W-1:0] {
        CFG_HALF_BW   = 2'd0,
        CFG_MAX_GAIN  = 2'd1,
        CFG_SIDE_GAIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                    dx_neg;
        logic                    dx_zero;
        logic                    dy_neg;
        logic                    dy_zero;
        logic signed [ANG_W-1:0] tx_beam;
        logic signed [ANG_W-1:0] rx_beam;
        logic signed [PWR_W-1:0] tx_power;
    } t_link_side;

    typedef struct packed {
        logic [1:0]              in_lobe;
        logic signed [PWR_W-1:0] tx_power;
    } t_lobe_side;

endpackage

### rtl/dbl_atan.sv
// dbl_atan: pipelined vectoring CORDIC giving the first-quadrant bearing of
// |dx|, |dy| in 1/128 degree. Depends on dbl_pkg.
module dbl_atan #(
    parameter int STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [dbl_pkg::DIFF_W-1:0]    i_dx,
    input  logic signed [dbl_pkg::DIFF_W-1:0]    i_dy,
    input  dbl_pkg::t_link_side                  i_side,
    output logic                                 o_valid,
    output logic [dbl_pkg::Q_W-1:0]              o_q,
    output dbl_pkg::t_link_side                  o_side
);
    import dbl_pkg::*;

    logic [STEPS+1:0]       r_v;
    logic signed [VX_W-1:0] r_x [STEPS+1];
    logic signed [VX_W-1:0] r_y [STEPS+1];
    logic signed [Z_W-1:0]  r_z [STEPS+1];
    t_link_side             r_s [STEPS+2];
    logic [Q_W-1:0]         r_q;

    logic signed [VX_W-1:0] n_x [STEPS+1];
    logic signed [VX_W-1:0] n_y [STEPS+1];
    logic signed [Z_W-1:0]  n_z [STEPS+1];
    logic [Q_W-1:0]         n_q;

    logic [DIFF_W-1:0]      ax;
    logic [DIFF_W-1:0]      ay;
    logic signed [VX_W-1:0] xs;
    logic signed [VX_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    logic [TAB_W-1:0]       zc;
    logic [TAB_W:0]         zr;

    always_comb begin
        ax = i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
        ay = i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
        n_x[0] = $signed({{(VX_W-DIFF_W-8){1'b0}}, ax, 8'd0});
        n_y[0] = $signed({{(VX_W-DIFF_W-8){1'b0}}, ay, 8'd0});
        n_z[0] = '0;
        xs = '0;
        ys = '0;
        at = '0;
        for (int k = 0; k < STEPS; k++) begin
            xs = r_x[k] >>> k;
            ys = r_y[k] >>> k;
            at = $signed({{(Z_W-TAB_W){1'b0}}, ATAN_TAB[k]});
            if (!r_y[k][VX_W-1]) begin
                n_x[k+1] = r_x[k] + ys;
                n_y[k+1] = r_y[k] - xs;
                n_z[k+1] = r_z[k] + at;
            end else begin
                n_x[k+1] = r_x[k] - ys;
                n_y[k+1] = r_y[k] + xs;
                n_z[k+1] = r_z[k] - at;
            end
        end
        if (r_z[STEPS][Z_W-1]) begin
            zc = '0;
        end else if (r_z[STEPS] > DEG90) begin
            zc = DEG90[TAB_W-1:0];
        end else begin
            zc = r_z[STEPS][TAB_W-1:0];
        end
        zr  = {1'b0, zc} + (TAB_W+1)'(256);
        n_q = zr[9+Q_W-1:9];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_s[0] <= i_side;
            for (int k = 1; k <= STEPS+1; k++) begin
                r_s[k] <= r_s[k-1];
            end
            r_q <= n_q;
        end
    end

    assign o_valid = r_v[STEPS+1];
    assign o_q     = r_q;
    assign o_side  = r_s[STEPS+1];

endmodule

### rtl/dbl_div.sv
// dbl_div: two-lane pipelined restoring divider, one quotient bit per stage,
// giving the lobe phase. Depends on dbl_pkg.
module dbl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [dbl_pkg::NUM_W-1:0]     i_num [2],
    input  logic [dbl_pkg::DV_W-1:0]      i_den,
    input  dbl_pkg::t_lobe_side           i_side,
    output logic                          o_valid,
    output logic [dbl_pkg::QUO_W-1:0]     o_quo [2],
    output dbl_pkg::t_lobe_side           o_side
);
    import dbl_pkg::*;

    logic [QUO_W-1:0]  r_v;
    logic [REM_W-1:0]  r_rem [QUO_W][2];
    logic [QUO_W-1:0]  r_q   [QUO_W][2];
    logic [NUM_W-1:0]  r_n   [QUO_W][2];
    t_lobe_side        r_s   [QUO_W];

    logic [REM_W-1:0]  n_rem [QUO_W][2];
    logic [QUO_W-1:0]  n_q   [QUO_W][2];
    logic [NUM_W-1:0]  n_n   [QUO_W][2];

    logic [REM_W-1:0]  s_rem;
    logic [QUO_W-1:0]  s_q;
    logic [NUM_W-1:0]  s_n;
    logic [REM_W:0]    step;

    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic nb,
                                                input logic [DV_W-1:0] den);
        logic [REM_W:0] t;
        logic [REM_W:0] d;
        t = {rem, nb};
        d = {1'b0, den};
        if (t >= d) begin
            div_step = {1'b1, REM_W'(t - d)};
        end else begin
            div_step = {1'b0, t[REM_W-1:0]};
        end
    endfunction

    always_comb begin
        s_rem = '0;
        s_q   = '0;
        s_n   = '0;
        step  = '0;
        for (int k = 0; k < QUO_W; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    s_n   = i_num[l];
                    s_rem = {1'b0, i_num[l][NUM_W-1:QUO_W]};
                    s_q   = '0;
                end else begin
                    s_n   = r_n[(k == 0) ? 0 : k-1][l];
                    s_rem = r_rem[(k == 0) ? 0 : k-1][l];
                    s_q   = r_q[(k == 0) ? 0 : k-1][l];
                end
                step = div_step(s_rem, s_n[QUO_W-1-k], i_den);
                s_q[QUO_W-1-k] = step[REM_W];
                n_rem[k][l] = step[REM_W-1:0];
                n_q[k][l]   = s_q;
                n_n[k][l]   = s_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QUO_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_n   <= n_n;
            r_s[0] <= i_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_valid  = r_v[QUO_W-1];
    assign o_quo[0] = r_q[QUO_W-1][0];
    assign o_quo[1] = r_q[QUO_W-1][1];
    assign o_side   = r_s[QUO_W-1];

endmodule

### rtl/dbl_cos.sv
// dbl_cos: two-lane pipelined rotation CORDIC giving cos(phase) in 2^-30,
// clamped to [0, 1]. Depends on dbl_pkg.
module dbl_cos #(
    parameter int STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [dbl_pkg::Z_W-1:0]    i_phase [2],
    input  dbl_pkg::t_lobe_side               i_side,
    output logic                              o_valid,
    output logic [dbl_pkg::COS_W-1:0]         o_cos [2],
    output dbl_pkg::t_lobe_side               o_side
);
    import dbl_pkg::*;

    logic [STEPS:0]         r_v;
    logic signed [RX_W-1:0] r_x [STEPS][2];
    logic signed [RX_W-1:0] r_y [STEPS][2];
    logic signed [Z_W-1:0]  r_p [STEPS][2];
    t_lobe_side             r_s [STEPS+1];
    logic [COS_W-1:0]       r_c [2];

    logic signed [RX_W-1:0] n_x [STEPS][2];
    logic signed [RX_W-1:0] n_y [STEPS][2];
    logic signed [Z_W-1:0]  n_p [STEPS][2];
    logic [COS_W-1:0]       n_c [2];

    logic signed [RX_W-1:0] sx;
    logic signed [RX_W-1:0] sy;
    logic signed [Z_W-1:0]  sp;
    logic signed [RX_W-1:0] xs;
    logic signed [RX_W-1:0] ys;
    logic signed [Z_W-1:0]  at;

    always_comb begin
        sx = '0;
        sy = '0;
        sp = '0;
        xs = '0;
        ys = '0;
        at = '0;
        for (int k = 0; k < STEPS; k++) begin
            for (int l = 0; l < 2; l++) begin
                if (k == 0) begin
                    sx = INV_K;
                    sy = '0;
                    sp = i_phase[l];
                end else begin
                    sx = r_x[(k == 0) ? 0 : k-1][l];
                    sy = r_y[(k == 0) ? 0 : k-1][l];
                    sp = r_p[(k == 0) ? 0 : k-1][l];
                end
                xs = sx >>> k;
                ys = sy >>> k;
                at = $signed({{(Z_W-TAB_W){1'b0}}, ATAN_TAB[k]});
                if (!sp[Z_W-1]) begin
                    n_x[k][l] = sx - ys;
                    n_y[k][l] = sy + xs;
                    n_p[k][l] = sp - at;
                end else begin
                    n_x[k][l] = sx + ys;
                    n_y[k][l] = sy - xs;
                    n_p[k][l] = sp + at;
                end
            end
        end
        for (int l = 0; l < 2; l++) begin
            if (r_x[STEPS-1][l][RX_W-1]) begin
                n_c[l] = '0;
            end else if (r_x[STEPS-1][l] > ONE30) begin
                n_c[l] = ONE30[COS_W-1:0];
            end else begin
                n_c[l] = r_x[STEPS-1][l][COS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_p <= n_p;
            r_c <= n_c;
            r_s[0] <= i_side;
            for (int k = 1; k <= STEPS; k++) begin
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_cos   = r_c;
    assign o_side  = r_s[STEPS];

endmodule

### rtl/dual_beam_link_power.sv
// dual_beam_link_power: top level of the link power pipeline with its
// configuration registers. Depends on dbl_pkg, dbl_atan, dbl_div, dbl_cos.
//
// Input channel: i_in_valid / o_in_stall carry one link per transaction
// (positions, both beam angles, transmit power). Output channel:
// o_out_valid / i_out_stall carry received power and the saturation flag.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// ready is always high. Write registers only while the pipeline is empty.
// Throughput: one transaction per cycle while the output is not stalled. The
// pipeline has 2*CORDIC_STEPS+32 register stages, including the two CORDIC
// pipelines and the 23-stage phase divider.
// All stages share one enable; when the output is valid and stalled the
// whole pipeline holds and o_in_stall is raised, so nothing is dropped.
// Reset clears all valid bits and loads the register defaults
// (15 deg half beamwidth, 10 dB peak gain, -20 dB side gain).
module dual_beam_link_power #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [23:0]  i_tx_x,
    input  logic signed [23:0]  i_tx_y,
    input  logic signed [23:0]  i_rx_x,
    input  logic signed [23:0]  i_rx_y,
    input  logic signed [15:0]  i_tx_beam,
    input  logic signed [15:0]  i_rx_beam,
    input  logic signed [15:0]  i_tx_power,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [17:0]  o_rx_power,
    output logic                o_saturated,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import dbl_pkg::*;

    logic en;

    logic [HBW_W-1:0]       r_hbw;
    logic [MG_W-1:0]        r_max_gain;
    logic signed [SG_W-1:0] r_side_gain;

    logic                    r_a_v;
    logic signed [DIFF_W-1:0] r_a_dx;
    logic signed [DIFF_W-1:0] r_a_dy;
    logic signed [ANG_W-1:0] r_a_tb;
    logic signed [ANG_W-1:0] r_a_rb;
    logic signed [PWR_W-1:0] r_a_pw;
    t_link_side              a_side;

    logic                    at_v;
    logic [Q_W-1:0]          at_q;
    t_link_side              at_side;

    logic                    r_b_v;
    logic signed [ANG_W-1:0] r_b_brg [2];
    logic signed [ANG_W-1:0] r_b_beam [2];
    logic signed [PWR_W-1:0] r_b_pw;

    logic                    r_c_v;
    logic [DV_W-1:0]         r_c_diff [2];
    logic signed [PWR_W-1:0] r_c_pw;

    logic                    r_d_v;
    logic [NUM_W-1:0]        r_d_num [2];
    t_lobe_side              r_d_side;

    logic                    dv_v;
    logic [QUO_W-1:0]        dv_quo [2];
    t_lobe_side              dv_side;
    logic signed [Z_W-1:0]   phase [2];

    logic                    cs_v;
    logic [COS_W-1:0]        cs_cos [2];
    t_lobe_side              cs_side;

    logic                    r_g_v;
    logic signed [GAIN_W-1:0] r_g [2];
    logic signed [PWR_W-1:0] r_g_pw;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_rx_power;
    logic                    r_sat;

    logic signed [ANG_W-1:0] n_brg [2];
    logic signed [GAIN_W-1:0] n_g [2];
    logic [PROD_W-1:0]       prod;
    logic signed [SUM_W-1:0] sum;

    function automatic logic signed [ANG_W-1:0] quad(input logic [Q_W-1:0] q,
                                                     input logic xp,
                                                     input logic yp);
        logic signed [ANG_W-1:0] qs;
        logic signed [ANG_W-1:0] h;
        qs = $signed({{(ANG_W-Q_W){1'b0}}, q});
        h  = $signed(ANG180[ANG_W-1:0]);
        if (xp) begin
            quad = yp ? qs : -qs;
        end else begin
            quad = yp ? (h - qs) : (qs - h);
        end
    endfunction

    function automatic logic [DV_W-1:0] fold(input logic signed [ANG_W-1:0] beam,
                                             input logic signed [ANG_W-1:0] brg);
        logic signed [ANG_W:0]   d;
        logic signed [ANG_W+1:0] a;
        logic signed [ANG_W+1:0] e;
        d = (ANG_W+1)'(beam) - (ANG_W+1)'(brg);
        a = d[ANG_W] ? -(ANG_W+2)'(d) : (ANG_W+2)'(d);
        if (a > ANG180) begin
            e = ANG360 - a;
            if (e[ANG_W+1]) begin
                e = -e;
            end
            fold = e[DV_W-1:0];
        end else begin
            fold = a[DV_W-1:0];
        end
    endfunction

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hbw       <= 15'd1920;
            r_max_gain  <= 15'd2560;
            r_side_gain <= -16'sd5120;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HALF_BW:   r_hbw       <= i_cfg_data[HBW_W-1:0];
                CFG_MAX_GAIN:  r_max_gain  <= i_cfg_data[MG_W-1:0];
                CFG_SIDE_GAIN: r_side_gain <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // stage A: position differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= DIFF_W'(i_rx_x) - DIFF_W'(i_tx_x);
            r_a_dy <= DIFF_W'(i_rx_y) - DIFF_W'(i_tx_y);
            r_a_tb <= i_tx_beam;
            r_a_rb <= i_rx_beam;
            r_a_pw <= i_tx_power;
        end
    end

    always_comb begin
        a_side.dx_neg   = r_a_dx[DIFF_W-1];
        a_side.dx_zero  = (r_a_dx == '0);
        a_side.dy_neg   = r_a_dy[DIFF_W-1];
        a_side.dy_zero  = (r_a_dy == '0);
        a_side.tx_beam  = r_a_tb;
        a_side.rx_beam  = r_a_rb;
        a_side.tx_power = r_a_pw;
    end

    dbl_atan #(
        .STEPS(CORDIC_STEPS)
    ) u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_dx    (r_a_dx),
        .i_dy    (r_a_dy),
        .i_side  (a_side),
        .o_valid (at_v),
        .o_q     (at_q),
        .o_side  (at_side)
    );

    // stage B: both bearings; reverse bearing uses the negated vector
    always_comb begin
        if (at_side.dx_zero && at_side.dy_zero) begin
            n_brg[0] = '0;
            n_brg[1] = '0;
        end else begin
            n_brg[0] = quad(at_q, !at_side.dx_neg, !at_side.dy_neg);
            n_brg[1] = quad(at_q, at_side.dx_neg || at_side.dx_zero,
                            at_side.dy_neg || at_side.dy_zero);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_brg[0]  <= n_brg[0];
            r_b_brg[1]  <= n_brg[1];
            r_b_beam[0] <= at_side.tx_beam;
            r_b_beam[1] <= at_side.rx_beam;
            r_b_pw      <= at_side.tx_power;
        end
    end

    // stage C: folded angle differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_diff[0] <= fold(r_b_beam[0], r_b_brg[0]);
            r_c_diff[1] <= fold(r_b_beam[1], r_b_brg[1]);
            r_c_pw      <= r_b_pw;
        end
    end

    // stage D: lobe test and phase numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                r_d_num[l]          <= NUM_W'(r_c_diff[l]) * DEG90_U;
                r_d_side.in_lobe[l] <= (r_c_diff[l] <= r_hbw);
            end
            r_d_side.tx_power <= r_c_pw;
        end
    end

    dbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_v),
        .i_num   (r_d_num),
        .i_den   (r_hbw),
        .i_side  (r_d_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign phase[0] = $signed({{(Z_W-QUO_W){1'b0}}, dv_quo[0]});
    assign phase[1] = $signed({{(Z_W-QUO_W){1'b0}}, dv_quo[1]});

    dbl_cos #(
        .STEPS(CORDIC_STEPS)
    ) u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_v),
        .i_phase (phase),
        .i_side  (dv_side),
        .o_valid (cs_v),
        .o_cos   (cs_cos),
        .o_side  (cs_side)
    );

    // stage G: gain per end
    always_comb begin
        prod = '0;
        for (int l = 0; l < 2; l++) begin
            prod = PROD_W'(r_max_gain) * PROD_W'(cs_cos[l]) + HALF30;
            if (!cs_side.in_lobe[l]) begin
                n_g[l] = GAIN_W'(r_side_gain);
            end else if (r_hbw == '0) begin
                n_g[l] = $signed({2'b0, r_max_gain});
            end else begin
                n_g[l] = $signed({1'b0, prod[PROD_W-1:30]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g[0] <= n_g[0];
            r_g[1] <= n_g[1];
            r_g_pw <= cs_side.tx_power;
        end
    end

    // output stage: sum and saturate
    always_comb begin
        sum = SUM_W'(r_g_pw) + SUM_W'(r_g[0]) + SUM_W'(r_g[1]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sum > OUT_MAX) begin
                r_rx_power <= OUT_MAX[OUT_W-1:0];
                r_sat      <= 1'b1;
            end else if (sum < OUT_MIN) begin
                r_rx_power <= OUT_MIN[OUT_W-1:0];
                r_sat      <= 1'b1;
            end else begin
                r_rx_power <= sum[OUT_W-1:0];
                r_sat      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_d_v       <= 1'b0;
            r_g_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_v       <= i_in_valid;
            r_b_v       <= at_v;
            r_c_v       <= r_b_v;
            r_d_v       <= r_c_v;
            r_g_v       <= cs_v;
            r_out_valid <= r_g_v;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rx_power  = r_rx_power;
    assign o_saturated = r_sat;

endmodule

### dv/dual_beam_link_power_tb.sv
// Self-checking testbench for dual_beam_link_power: random and directed links,
// results predicted in SystemVerilog and compared in order. Depends on dbl_pkg.
module dual_beam_link_power_tb;
    import dbl_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = 2 * STEPS + 32;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam longint ATAN_LUT [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [17:0] rx_power;
        logic               saturated;
    } t_link_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [23:0] i_tx_x = '0, i_tx_y = '0, i_rx_x = '0, i_rx_y = '0;
    logic signed [15:0] i_tx_beam = '0, i_rx_beam = '0, i_tx_power = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [17:0] o_rx_power;
    logic o_saturated;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    dual_beam_link_power #(.CORDIC_STEPS(STEPS)) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    longint half_bw_q, max_gain_q, side_gain_q;
    t_link_result expected_links[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint link_bearing(longint dx, longint dy);
        longint x, y, z, q, xs, ys;
        x = (dx < 0 ? -dx : dx) * 256;
        y = (dy < 0 ? -dy : dy) * 256;
        z = 0;
        if (dx == 0 && dy == 0) return 0;
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_LUT[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_LUT[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 5898240) z = 5898240;
        q = (z + 256) / 512;
        if (dx >= 0) return dy >= 0 ? q : -q;
        return dy >= 0 ? 23040 - q : q - 23040;
    endfunction

    function automatic longint lobe_gain(longint beam, longint brg);
        longint diff, phase, x, y, xs, ys;
        diff = beam - brg;
        x = 652032874;
        y = 0;
        if (diff < 0) diff = -diff;
        if (diff > 23040) diff = 46080 - diff;
        if (diff < 0) diff = -diff;
        if (diff > half_bw_q) return side_gain_q;
        if (half_bw_q == 0) return max_gain_q;
        phase = diff * 5898240 / half_bw_q;
        for (int i = 0; i < STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (phase >= 0) begin
                x -= ys; y += xs; phase -= ATAN_LUT[i];
            end else begin
                x += ys; y -= xs; phase += ATAN_LUT[i];
            end
        end
        if (x < 0) x = 0;
        if (x > 1073741824) x = 1073741824;
        return (max_gain_q * x + 536870912) >>> 30;
    endfunction

    function automatic t_link_result predict_link(longint txx, longint txy, longint rxx,
                                                  longint rxy, longint tb, longint rb,
                                                  longint pw);
        t_link_result r;
        longint dx, dy, sum;
        dx = rxx - txx;
        dy = rxy - txy;
        sum = pw + lobe_gain(tb, link_bearing(dx, dy)) + lobe_gain(rb, link_bearing(-dx, -dy));
        r.saturated = 1'b0;
        if (sum > 131071) begin
            sum = 131071; r.saturated = 1'b1;
        end
        if (sum < -131072) begin
            sum = -131072; r.saturated = 1'b1;
        end
        r.rx_power = sum[17:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("tb: mismatch %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_links.size() == 0) begin
                report_mismatch("unexpected transaction", o_rx_power, 0);
            end else begin
                want = expected_links.pop_front();
                if (o_rx_power !== want.rx_power)
                    report_mismatch("rx_power", o_rx_power, want.rx_power);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
        if (recv_idle_pct > 0) i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        else i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_HALF_BW:   half_bw_q = data[14:0];
            CFG_MAX_GAIN:  max_gain_q = data[14:0];
            CFG_SIDE_GAIN: side_gain_q = $signed(data);
            default: ;
        endcase
    endtask

    task automatic send_link(logic signed [23:0] txx, logic signed [23:0] txy,
                             logic signed [23:0] rxx, logic signed [23:0] rxy,
                             logic signed [15:0] tb, logic signed [15:0] rb,
                             logic signed [15:0] pw);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_tx_x <= txx; i_tx_y <= txy; i_rx_x <= rxx; i_rx_y <= rxy;
        i_tx_beam <= tb; i_rx_beam <= rb; i_tx_power <= pw;
        do @(posedge i_clk); while (o_in_stall);
        expected_links.push_back(predict_link(txx, txy, rxx, rxy, tb, rb, pw));
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_links.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_beam();
        return $signed(16'($urandom_range(46080))) - 16'sd23040;
    endfunction

    task automatic test_directed();
        send_link(0, 0, 0, 0, 0, 0, 0);
        send_link(0, 0, 1000, 0, 0, 23040, 0);
        send_link(0, 0, 0, 1000, 11520, -11520, 100);
        send_link(0, 0, -1000, 0, 23040, 0, -100);
        send_link(0, 0, -1000, 0, -23040, 0, 32767);
        send_link(0, 0, 0, -1000, -11520, 11520, -32768);
        send_link(-24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607,
                  5760, -17280, 32767);
        send_link(24'sd8388607, 24'sd8388607, -24'sd8388608, -24'sd8388608,
                  -17280, 5760, -32768);
        send_link(0, 0, 100, 3, 16'sd32767, -16'sd32768, 0);
        send_link(0, 0, 100, -3, -16'sd32768, 16'sd32767, 0);
        send_link(5, 5, 6, 5, 1920, -21120, 0);
        send_link(5, 5, 6, 5, 1921, -21119, 0);
        send_link(0, 0, 1, 1, 5760, -17280, 1234);
        send_link(0, 0, 24'sd8388607, -24'sd8388608, 0, 0, 0);
        drain_pipeline();
    endtask

    task automatic test_random_links(int count, int hbw_max);
        logic signed [23:0] tx, ty, rx, ry;
        logic signed [15:0] tb, rb, pw;
        for (int n = 0; n < count; n++) begin
            tx = 24'($urandom); ty = 24'($urandom);
            if ($urandom_range(3) == 0) begin
                rx = 24'($urandom); ry = 24'($urandom);
            end else begin
                rx = tx + $signed(24'($urandom_range(2000))) - 24'sd1000;
                ry = ty + $signed(24'($urandom_range(2000))) - 24'sd1000;
            end
            tb = rand_beam(); rb = rand_beam(); pw = 16'($urandom);
            if ($urandom_range(1)) begin
                tb = 16'(link_bearing(rx - tx, ry - ty)
                          + $signed(32'($urandom_range(2 * hbw_max))) - hbw_max);
                rb = 16'(link_bearing(tx - rx, ty - ry)
                          + $signed(32'($urandom_range(2 * hbw_max))) - hbw_max);
            end
            if ($urandom_range(19) == 0) begin
                tb = 16'($urandom); rb = 16'($urandom);
            end
            send_link(tx, ty, rx, ry, tb, rb, pw);
        end
        drain_pipeline();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_HALF_BW, 16'd23040);
        write_reg(CFG_MAX_GAIN, 16'd32767);
        write_reg(CFG_SIDE_GAIN, 16'h8000);
        test_random_links(300, 23040);
        write_reg(CFG_HALF_BW, 16'd1);
        write_reg(CFG_MAX_GAIN, 16'd0);
        write_reg(CFG_SIDE_GAIN, 16'd0);
        test_random_links(150, 2);
        write_reg(CFG_HALF_BW, 16'd0);
        write_reg(CFG_MAX_GAIN, 16'd12345);
        write_reg(CFG_SIDE_GAIN, 16'd300);
        send_link(0, 0, 1000, 0, 0, 23040, 0);
        test_random_links(100, 1);
        write_reg(CFG_HALF_BW, 16'hFFFF);
        write_reg(CFG_MAX_GAIN, 16'hFFFF);
        write_reg(CFG_SIDE_GAIN, 16'h7FFF);
        write_reg(t_cfg_idx'(2'd3), 16'h1234);
        test_random_links(100, 16000);
        write_reg(CFG_HALF_BW, 16'($urandom_range(23040, 1)));
        write_reg(CFG_MAX_GAIN, 16'($urandom_range(32767)));
        write_reg(CFG_SIDE_GAIN, 16'(-$urandom_range(32768)));
        test_random_links(200, 4000);
    endtask

    initial begin
        half_bw_q = 1920;
        max_gain_q = 2560;
        side_gain_q = -5120;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 9;
        recv_idle_pct = 68;
        test_directed();
        test_random_links(300, 1920);
        send_idle_pct = 68;
        recv_idle_pct = 9;
        test_random_links(300, 1920);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_links(300, 1920);
        test_config_extremes();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
